[hw/rtl/sshash_pkg.sv]
// ----------------------------------------------------------------------------
// sshash_pkg
// Shared types, constants and shift tables of the sampled string scramble hash.
// ----------------------------------------------------------------------------
`default_nettype none

package sshash_pkg;

    localparam int DEF_LENGTH_BITS = 32;
    localparam int BYTE_W          = 8;
    localparam int LEN_IN_W        = 32;
    localparam int HASH_W          = 64;
    localparam int HALF_W          = 32;
    localparam int SHIFT_W         = 6;

    // strings up to these lengths sample every byte
    localparam int SHORT64_MAX = 15;
    localparam int SHORT32_MAX = 7;

    // last head position, largest distance below the middle, and tail byte count
    localparam int HEAD64_LAST = 4;
    localparam int MID64_SPAN  = 4;
    localparam int TAIL64_SPAN = 5;
    localparam int HEAD32_LAST = 2;

    typedef struct packed {
        logic               hit;
        logic [SHIFT_W-1:0] shamt;
    } t_pick;

    function automatic logic [SHIFT_W-1:0] sh64_short(input logic [3:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            4'd0:    s = 6'd48;
            4'd1:    s = 6'd56;
            4'd2:    s = 6'd52;
            4'd3:    s = 6'd36;
            4'd4:    s = 6'd44;
            4'd5:    s = 6'd60;
            4'd6:    s = 6'd40;
            4'd7:    s = 6'd32;
            4'd8:    s = 6'd16;
            4'd9:    s = 6'd24;
            4'd10:   s = 6'd20;
            4'd11:   s = 6'd4;
            4'd12:   s = 6'd12;
            4'd13:   s = 6'd28;
            4'd14:   s = 6'd8;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SHIFT_W-1:0] sh64_head(input logic [2:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            3'd0:    s = 6'd20;
            3'd1:    s = 6'd4;
            3'd2:    s = 6'd12;
            3'd3:    s = 6'd28;
            3'd4:    s = 6'd8;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SHIFT_W-1:0] sh64_mid(input logic [2:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            3'd0:    s = 6'd60;
            3'd1:    s = 6'd40;
            3'd2:    s = 6'd32;
            3'd3:    s = 6'd16;
            3'd4:    s = 6'd24;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SHIFT_W-1:0] sh64_tail(input logic [2:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            3'd0:    s = 6'd48;
            3'd1:    s = 6'd56;
            3'd2:    s = 6'd52;
            3'd3:    s = 6'd36;
            3'd4:    s = 6'd44;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SHIFT_W-1:0] sh32_short(input logic [2:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            3'd0:    s = 6'd16;
            3'd1:    s = 6'd24;
            3'd2:    s = 6'd20;
            3'd3:    s = 6'd4;
            3'd4:    s = 6'd12;
            3'd5:    s = 6'd28;
            3'd6:    s = 6'd8;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SHIFT_W-1:0] sh32_head(input logic [1:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            2'd0:    s = 6'd12;
            2'd1:    s = 6'd28;
            2'd2:    s = 6'd8;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    // index is distance below the middle byte
    function automatic logic [SHIFT_W-1:0] sh32_mid(input logic idx);
        return idx ? 6'd4 : 6'd20;
    endfunction

    // index is distance from the end, minus one
    function automatic logic [SHIFT_W-1:0] sh32_tail(input logic idx);
        return idx ? 6'd24 : 6'd16;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sshash_in_if.sv]
// ----------------------------------------------------------------------------
// sshash_in_if
// Byte channel: one string byte per transaction with length and last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface sshash_in_if;
    logic                             valid;
    logic                             ready;
    logic [sshash_pkg::BYTE_W-1:0]    byte_value;
    logic [sshash_pkg::LEN_IN_W-1:0]  string_length;
    logic                             last_byte;

    modport source (
        output valid, byte_value, string_length, last_byte,
        input  ready
    );

    modport sink (
        input  valid, byte_value, string_length, last_byte,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/sshash_out_if.sv]
// ----------------------------------------------------------------------------
// sshash_out_if
// Hash channel: one hash value per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sshash_out_if;
    logic                           valid;
    logic                           ready;
    logic [sshash_pkg::HASH_W-1:0]  hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );

    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/sshash_pick.sv]
// ----------------------------------------------------------------------------
// sshash_pick
// Decides whether the byte at the current position is sampled and its shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sshash_pick #(
    parameter int LENGTH_BITS = sshash_pkg::DEF_LENGTH_BITS
) (
    input  wire logic [LENGTH_BITS-1:0] i_len,
    input  wire logic [LENGTH_BITS-1:0] i_pos,
    input  wire logic                   i_wide,
    output sshash_pkg::t_pick           o_pick
);

    localparam int LB = LENGTH_BITS;

    logic [LB-1:0] remain;    // bytes left including this one
    logic [LB-1:0] mid64;
    logic [LB-1:0] mid32;
    logic [LB:0]   below64;   // borrow bit on top
    logic [LB:0]   below32;
    logic          in_range;

    assign in_range = i_pos < i_len;
    assign remain   = i_len - i_pos;
    assign mid64    = (i_len >> 1) + LB'(1);
    assign mid32    = i_len >> 1;
    assign below64  = {1'b0, mid64} - {1'b0, i_pos};
    assign below32  = {1'b0, mid32} - {1'b0, i_pos};

    always_comb begin
        o_pick.hit   = 1'b0;
        o_pick.shamt = '0;
        if (in_range) begin
            if (i_wide) begin
                if (i_len <= LB'(sshash_pkg::SHORT64_MAX)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh64_short(
                        4'(sshash_pkg::SHORT64_MAX) - remain[3:0]);
                end else if (i_pos <= LB'(sshash_pkg::HEAD64_LAST)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh64_head(i_pos[2:0]);
                end else if (!below64[LB] &&
                             below64[LB-1:0] <= LB'(sshash_pkg::MID64_SPAN)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh64_mid(below64[2:0]);
                end else if (remain <= LB'(sshash_pkg::TAIL64_SPAN)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh64_tail(remain[2:0] - 3'd1);
                end
            end else begin
                if (i_len <= LB'(sshash_pkg::SHORT32_MAX)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh32_short(
                        3'(sshash_pkg::SHORT32_MAX) - remain[2:0]);
                end else if (i_pos <= LB'(sshash_pkg::HEAD32_LAST)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh32_head(i_pos[1:0]);
                end else if (!below32[LB] && below32[LB-1:0] <= LB'(1)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh32_mid(below32[0]);
                end else if (remain <= LB'(2)) begin
                    o_pick.hit   = 1'b1;
                    o_pick.shamt = sshash_pkg::sh32_tail(~remain[0]);
                end
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sshash_accum.sv]
// ----------------------------------------------------------------------------
// sshash_accum
// Position counter, running sum and result register of the hash.
// ----------------------------------------------------------------------------
`default_nettype none

module sshash_accum #(
    parameter int LENGTH_BITS = sshash_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_advance,
    input  wire logic [sshash_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [LENGTH_BITS-1:0]          i_len,
    input  wire logic                            i_last,
    input  wire logic                            i_wide,
    input  wire sshash_pkg::t_pick               i_pick,
    input  wire logic                            i_out_ready,
    output logic [LENGTH_BITS-1:0]               o_pos,
    output logic                                 o_out_valid,
    output logic [sshash_pkg::HASH_W-1:0]        o_hash
);

    localparam int HW = sshash_pkg::HASH_W;
    localparam int BW = sshash_pkg::BYTE_W;

    logic [LENGTH_BITS-1:0] r_pos,   n_pos;
    logic [HW-1:0]          r_sum,   n_sum;
    logic                   r_valid, n_valid;
    logic [HW-1:0]          r_hash,  n_hash;
    logic [HW-1:0]          base;
    logic [HW-1:0]          sext;
    logic [HW-1:0]          term;
    logic [HW-1:0]          total;
    logic                   empty;

    assign empty = (i_len == '0);
    assign base  = (r_pos == '0) ? HW'(i_len) : r_sum;
    assign sext  = {{(HW-BW){i_byte[BW-1]}}, i_byte};
    assign term  = i_pick.hit ? (sext << i_pick.shamt) : '0;
    assign total = base + term;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_valid = r_valid & ~i_out_ready;
        n_hash  = r_hash;
        if (i_advance) begin
            if (empty) begin
                n_pos   = '0;
                n_sum   = '0;
                n_valid = 1'b1;
                n_hash  = '0;
            end else if (i_last) begin
                n_pos   = '0;
                n_sum   = '0;
                n_valid = 1'b1;
                n_hash  = i_wide ? total
                                 : {{(HW-sshash_pkg::HALF_W){1'b0}},
                                    total[sshash_pkg::HALF_W-1:0]};
            end else begin
                n_pos = r_pos + LENGTH_BITS'(1);
                n_sum = total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_pos       = r_pos;
    assign o_out_valid = r_valid;
    assign o_hash      = r_hash;

endmodule

`default_nettype wire

[hw/rtl/sampled_string_scramble_hash.sv]
// ----------------------------------------------------------------------------
// sampled_string_scramble_hash
// Hashes a byte stream by summing shifted bytes at length-dependent positions.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one string byte per transaction, together with the total
//   string length and a last mark. A transaction with length zero stands for
//   the empty string and yields a hash of zero on its own.
//   o_out carries one hash per string, produced for the transaction that has
//   the last mark set.
//   i_cfg_we/i_cfg_wdata write the mode bit (1: 64-bit hash, 0: 32-bit hash);
//   write it only while no string is in flight.
// Timing:
//   a byte is registered at its accepting edge and folded into the sum at
//   the next edge, unless it would give a result while one is still held;
//   the hash is registered as the last byte is folded in. One byte is taken
//   every cycle while no result is held back; the limit is the position
//   compare, shift select and 64-bit add between the input and sum registers.
// Reset:
//   clears the position, the sum and both valid flags; the mode returns to 64.
// Stall:
//   a held result keeps its register; bytes that give no result still flow,
//   and a byte that would give a result waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module sampled_string_scramble_hash #(
    parameter int LENGTH_BITS = sshash_pkg::DEF_LENGTH_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sshash_in_if.sink   i_in,
    sshash_out_if.source o_out,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata
);

    localparam int LB = LENGTH_BITS;

    logic                            r_wide;
    logic                            r_in_valid, n_in_valid;
    logic [sshash_pkg::BYTE_W-1:0]   r_byte;
    logic [LB-1:0]                   r_len;
    logic                            r_last;
    logic                            in_take;
    logic                            advance;
    logic                            gives_result;
    logic                            out_valid;
    logic [LB-1:0]                   pos;
    sshash_pkg::t_pick               pick;

    assign gives_result = r_last | (r_len == '0);
    assign advance      = r_in_valid & (~gives_result | ~out_valid | o_out.ready);
    assign i_in.ready   = ~r_in_valid | advance;
    assign in_take      = i_in.valid & i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide     <= 1'b1;
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_wide <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_in.byte_value;
            r_len  <= LB'(i_in.string_length);
            r_last <= i_in.last_byte;
        end
    end

    sshash_pick #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_pick (
        .i_len  (r_len),
        .i_pos  (pos),
        .i_wide (r_wide),
        .o_pick (pick)
    );

    sshash_accum #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_byte),
        .i_len       (r_len),
        .i_last      (r_last),
        .i_wide      (r_wide),
        .i_pick      (pick),
        .i_out_ready (o_out.ready),
        .o_pos       (pos),
        .o_out_valid (out_valid),
        .o_hash      (o_out.hash_value)
    );

    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

[dv/sshash_checker.sv]
// ----------------------------------------------------------------------------
// sshash_checker
// Watches the byte and hash channels of the sampled string scramble hash.
// It tracks the mode bit from the register port and folds every accepted
// byte into its own copy of the position and the sum. Each accepted hash is
// compared with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module sshash_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sshash_in_if      byte_ch,
    sshash_out_if     hash_ch,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SH64_SHORT [15] = '{48, 56, 52, 36, 44, 60, 40, 32, 16, 24, 20, 4, 12, 28, 8};
    localparam int SH64_HEAD  [5]  = '{20, 4, 12, 28, 8};
    localparam int SH64_MID   [5]  = '{60, 40, 32, 16, 24};
    localparam int SH64_TAIL  [5]  = '{48, 56, 52, 36, 44};
    localparam int SH32_SHORT [7]  = '{16, 24, 20, 4, 12, 28, 8};
    localparam int SH32_HEAD  [3]  = '{12, 28, 8};
    localparam int SH32_MID   [2]  = '{20, 4};
    localparam int SH32_TAIL  [2]  = '{16, 24};

    logic                                     wide_mode;
    logic [sshash_pkg::DEF_LENGTH_BITS-1:0]   byte_pos;
    logic [sshash_pkg::HASH_W-1:0]            run_sum;
    logic [sshash_pkg::HASH_W-1:0]            hash_q [$];

    // shift for byte p of a string of length n, -1 when the byte is skipped
    function automatic int pick_shift(input bit wide, input longint unsigned n,
                                      input longint unsigned p);
        longint unsigned m;
        if (p >= n)
            return -1;
        if (wide) begin
            if (n <= 15)
                return SH64_SHORT[15 - n + p];
            if (p <= 4)
                return SH64_HEAD[p];
            m = n / 2 + 1;
            if (p <= m && p + 4 >= m)
                return SH64_MID[m - p];
            if (p + 5 >= n)
                return SH64_TAIL[n - 1 - p];
            return -1;
        end
        if (n <= 7)
            return SH32_SHORT[7 - n + p];
        if (p <= 2)
            return SH32_HEAD[p];
        m = n / 2;
        if (p == m || p + 1 == m)
            return SH32_MID[m - p];
        if (p + 2 >= n)
            return SH32_TAIL[n - 1 - p];
        return -1;
    endfunction

    function automatic void absorb_byte(input logic [sshash_pkg::BYTE_W-1:0] b,
                                        input logic [sshash_pkg::LEN_IN_W-1:0] len,
                                        input logic last);
        logic [sshash_pkg::HASH_W-1:0] ext;
        int                            sh;
        if (len == '0) begin
            // empty string answers on its own, last mark or not
            byte_pos = '0;
            run_sum  = '0;
            hash_q.push_back('0);
            return;
        end
        if (byte_pos == '0)
            run_sum = {{(sshash_pkg::HASH_W-sshash_pkg::LEN_IN_W){1'b0}}, len};
        ext = {{(sshash_pkg::HASH_W-sshash_pkg::BYTE_W){b[sshash_pkg::BYTE_W-1]}}, b};
        sh  = pick_shift(wide_mode, longint'(len), longint'(byte_pos));
        if (sh >= 0)
            run_sum = run_sum + (ext << sh);
        byte_pos = byte_pos + 1'b1;
        if (last) begin
            hash_q.push_back(wide_mode ? run_sum : {32'd0, run_sum[31:0]});
            byte_pos = '0;
            run_sum  = '0;
        end
    endfunction

    function automatic void check_hash(input logic [sshash_pkg::HASH_W-1:0] act);
        logic [sshash_pkg::HASH_W-1:0] exp_hash;
        if (hash_q.size() == 0) begin
            $error("hash_value: expected none, actual %h", act);
            o_errors++;
            return;
        end
        exp_hash = hash_q.pop_front();
        if (act !== exp_hash) begin
            $error("hash_value: expected %h, actual %h", exp_hash, act);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wide_mode = 1'b1;
            byte_pos  = '0;
            run_sum   = '0;
            hash_q.delete();
            o_errors  = 0;
        end else begin
            // a hash leaving now belongs to an earlier byte, so pop first
            if (hash_ch.valid && hash_ch.ready)
                check_hash(hash_ch.hash_value);
            if (byte_ch.valid && byte_ch.ready)
                absorb_byte(byte_ch.byte_value, byte_ch.string_length, byte_ch.last_byte);
            if (i_cfg_we)
                wide_mode = i_cfg_wdata;
        end
        o_pending = hash_q.size();
    end

endmodule

`default_nettype wire

[dv/tb_sampled_string_scramble_hash.sv]
// ----------------------------------------------------------------------------
// tb_sampled_string_scramble_hash
// Drives strings into the sampled string scramble hash in both modes: a
// directed set of corner strings, then random well-formed strings mixed with
// empty, truncated, overrun and length-changing ones, under random idling,
// a long output stall and a full drain. The checker does the comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sampled_string_scramble_hash;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int WDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 360;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   errors;
    int   pending;
    int   items_sent;
    int   stall_requests;
    bit   gaps_on;
    int   idle_cycles;

    sshash_in_if  byte_ch ();
    sshash_out_if hash_ch ();

    sampled_string_scramble_hash uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (byte_ch),
        .o_out       (hash_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    sshash_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .byte_ch     (byte_ch),
        .hash_ch     (hash_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hash receiver: random back-pressure plus one long hold-off on request
    initial begin
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        hash_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (stall_seen != stall_requests) begin
                stall_seen = stall_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                hash_ch.ready <= 1'b0;
            end else begin
                hash_ch.ready <= !(gaps_on && $urandom_range(99) < 12);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (hash_ch.valid && hash_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb_sampled_string_scramble_hash: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // entered right after an accepting edge; returns at the edge that accepts
    task automatic send_item(input logic [sshash_pkg::BYTE_W-1:0] b,
                             input logic [sshash_pkg::LEN_IN_W-1:0] len,
                             input logic last);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 12) begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.byte_value    <= b;
        byte_ch.string_length <= len;
        byte_ch.last_byte     <= last;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_run(input logic [sshash_pkg::LEN_IN_W-1:0] len, input int count);
        for (int i = 0; i < count; i++)
            send_item(8'($urandom()), len, i == count - 1);
    endtask

    // drop valid and wait until every predicted hash has come out
    task automatic drain();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic wide);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= wide;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(1, 16);
        if (r < 85)
            return $urandom_range(16, 40);
        if (r < 97)
            return $urandom_range(41, 100);
        return $urandom_range(101, 300);
    endfunction

    task automatic send_random_string();
        int                            kind;
        int                            n;
        int                            k;
        logic [sshash_pkg::LEN_IN_W-1:0] len;
        kind = $urandom_range(99);
        if (kind < 72) begin
            n = pick_len();
            send_run(n, n);
        end else if (kind < 80) begin
            // last mark before the stated length, often a huge one
            len = $urandom_range(1) ? 32'($urandom()) : 32'($urandom_range(2, 100));
            if (len < 2)
                len = 2;
            k = (len > 30) ? $urandom_range(1, 30) : $urandom_range(1, len - 1);
            send_run(len, k);
        end else if (kind < 87) begin
            // runs past its length before the last mark shows up
            n = $urandom_range(1, 20);
            send_run(n, n + $urandom_range(1, 6));
        end else if (kind < 93) begin
            n = pick_len();
            for (int i = 0; i < n; i++)
                send_item(8'($urandom()), $urandom_range(1) ? n : $urandom_range(1, 64),
                          i == n - 1);
        end else begin
            send_item(8'($urandom()), '0, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(input int n_items, input int hold_at, input int pause_at);
        int start;
        bit held;
        bit paused;
        start  = items_sent;
        held   = 0;
        paused = 0;
        while (items_sent - start < n_items) begin
            if (hold_at >= 0 && !held && items_sent - start >= hold_at) begin
                stall_requests++;
                held = 1;
            end
            if (pause_at >= 0 && !paused && items_sent - start >= pause_at) begin
                drain();
                paused = 1;
            end
            send_random_string();
        end
    endtask

    initial begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.byte_value    <= '0;
        byte_ch.string_length <= '0;
        byte_ch.last_byte     <= 1'b0;
        items_sent     = 0;
        stall_requests = 0;
        gaps_on        = 1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        set_mode(1'b1);
        // empty strings with and without the last mark
        send_item(8'hff, '0, 1'b0);
        send_item(8'h00, '0, 1'b1);
        // single bytes at the sign extremes, then a two-byte string
        send_item(8'h80, 32'd1, 1'b1);
        send_item(8'h7f, 32'd1, 1'b1);
        send_item(8'hff, 32'd2, 1'b0);
        send_item(8'h01, 32'd2, 1'b1);
        // shortest string that uses head, middle and tail windows
        for (int i = 0; i < 16; i++)
            send_item((i % 2) ? 8'h80 : 8'hff, 32'd16, i == 15);
        // maximum length, cut short by the last mark
        send_item(8'h80, 32'hffff_ffff, 1'b1);
        // byte past the stated length
        send_item(8'h55, 32'd1, 1'b0);
        send_item(8'haa, 32'd1, 1'b1);

        set_mode(1'b0);
        run_random(PHASE_ITEMS, 100, -1);
        set_mode(1'b1);
        gaps_on = 0;
        run_random(PHASE_ITEMS, -1, -1);
        gaps_on = 1;
        set_mode(1'b0);
        run_random(PHASE_ITEMS, -1, 150);
        set_mode(1'b1);
        run_random(PHASE_ITEMS, -1, -1);

        drain();
        if (errors == 0)
            $display("tb_sampled_string_scramble_hash: clean");
        else
            $display("tb_sampled_string_scramble_hash: errors");
        $finish;
    end

endmodule

`default_nettype wire
